>>> rtl/sbpm_pkg.sv
// Shared types, codes and constants of the size-banded proximity merge block.
// Used by all modules under rtl; no dependencies of its own.
package sbpm_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 20;

    localparam int HITS_W     = 17;
    localparam int CUT_W      = 43;
    localparam int REASON_W   = 3;
    localparam int CMD_W      = 2;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [HITS_W-1:0] SMALL_MIN_RST = 17'd0;
    localparam logic [HITS_W-1:0] SMALL_MAX_RST = 17'd15;
    localparam logic [HITS_W-1:0] BIG_MIN_RST   = 17'd50;
    localparam logic [HITS_W-1:0] BIG_MAX_RST   = 17'd99999;
    localparam logic [CUT_W-1:0]  CUT_RST       = 43'd0;

    // Input commands; the fourth code is ignored
    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECIDE = 2'd2;

    // Result reason codes, in rule order
    localparam logic [REASON_W-1:0] REASON_NONE_SMALL = 3'd0;
    localparam logic [REASON_W-1:0] REASON_NONE_BIG   = 3'd1;
    localparam logic [REASON_W-1:0] REASON_BOTH_SMALL = 3'd2;
    localparam logic [REASON_W-1:0] REASON_BOTH_BIG   = 3'd3;
    localparam logic [REASON_W-1:0] REASON_NO_CLOSE   = 3'd4;
    localparam logic [REASON_W-1:0] REASON_CLOSE      = 3'd5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SMALL_MIN = 3'd0,
        REG_SMALL_MAX = 3'd1,
        REG_BIG_MIN   = 3'd2,
        REG_BIG_MAX   = 3'd3,
        REG_DIST_CUT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [HITS_W-1:0] small_min;
        logic [HITS_W-1:0] small_max;
        logic [HITS_W-1:0] big_min;
        logic [HITS_W-1:0] big_max;
        logic [CUT_W-1:0]  dist_cut;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic busy;
    } pair_stat_t;

    function automatic logic in_band(input logic [HITS_W-1:0] n,
                                     input logic [HITS_W-1:0] lo,
                                     input logic [HITS_W-1:0] hi);
        return (n > lo) && (n < hi);
    endfunction

endpackage

>>> rtl/sbpm_regs.sv
// APB configuration registers: hit-count bands and squared-distance cut.
// Depends on sbpm_pkg.
module sbpm_regs
    import sbpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SMALL_MIN: cfg_next.small_min = pwdata[HITS_W-1:0];
                REG_SMALL_MAX: cfg_next.small_max = pwdata[HITS_W-1:0];
                REG_BIG_MIN:   cfg_next.big_min   = pwdata[HITS_W-1:0];
                REG_BIG_MAX:   cfg_next.big_max   = pwdata[HITS_W-1:0];
                REG_DIST_CUT:  cfg_next.dist_cut  = pwdata[CUT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SMALL_MIN: prdata = {{(APB_DATA_W-HITS_W){1'b0}}, cfg_reg.small_min};
            REG_SMALL_MAX: prdata = {{(APB_DATA_W-HITS_W){1'b0}}, cfg_reg.small_max};
            REG_BIG_MIN:   prdata = {{(APB_DATA_W-HITS_W){1'b0}}, cfg_reg.big_min};
            REG_BIG_MAX:   prdata = {{(APB_DATA_W-HITS_W){1'b0}}, cfg_reg.big_max};
            REG_DIST_CUT:  prdata = {{(APB_DATA_W-CUT_W){1'b0}}, cfg_reg.dist_cut};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_min <= SMALL_MIN_RST;
            cfg_reg.small_max <= SMALL_MAX_RST;
            cfg_reg.big_min   <= BIG_MIN_RST;
            cfg_reg.big_max   <= BIG_MAX_RST;
            cfg_reg.dist_cut  <= CUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/sbpm_point_store.sv
// Vertex memory of one cluster: one write port, one registered read port.
// Depends on sbpm_pkg for parameter defaults.
module sbpm_point_store
    import sbpm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [COORD_BITS-1:0] wr_wire,
    input  logic [COORD_BITS-1:0] wr_time,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [COORD_BITS-1:0] rd_wire,
    output logic [COORD_BITS-1:0] rd_time
);

    logic [2*COORD_BITS-1:0] mem_reg [MAX_POINTS];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= {wr_wire, wr_time};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_wire = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_time = rd_data_reg[COORD_BITS-1:0];

endmodule

>>> rtl/sbpm_pair_unit.sv
// Three-stage squared-distance pipeline: difference, square, sum and compare.
// Depends on sbpm_pkg.
module sbpm_pair_unit
    import sbpm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_en,
    input  logic [COORD_BITS-1:0] a_wire,
    input  logic [COORD_BITS-1:0] a_time,
    input  logic [COORD_BITS-1:0] b_wire,
    input  logic [COORD_BITS-1:0] b_time,
    input  logic [CUT_W-1:0]      dist_cut,
    output pair_stat_t            stat
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > CUT_W) ? SUM_W : CUT_W;

    logic signed [DIFF_W-1:0] d_wire;
    logic signed [DIFF_W-1:0] d_time;
    logic [DIFF_W-1:0]        abs_wire_reg;
    logic [DIFF_W-1:0]        abs_time_reg;
    logic [SQ_W-1:0]          sq_wire_reg;
    logic [SQ_W-1:0]          sq_time_reg;
    logic [SUM_W-1:0]         sum;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     hit_reg;

    assign d_wire = $signed({b_wire[COORD_BITS-1], b_wire})
                  - $signed({a_wire[COORD_BITS-1], a_wire});
    assign d_time = $signed({b_time[COORD_BITS-1], b_time})
                  - $signed({a_time[COORD_BITS-1], a_time});
    assign sum    = {1'b0, sq_wire_reg} + {1'b0, sq_time_reg};

    // Payload stages
    always_ff @(posedge clk)
    begin
        abs_wire_reg <= d_wire[DIFF_W-1] ? DIFF_W'(-d_wire) : DIFF_W'(d_wire);
        abs_time_reg <= d_time[DIFF_W-1] ? DIFF_W'(-d_time) : DIFF_W'(d_time);
        sq_wire_reg  <= abs_wire_reg * abs_wire_reg;
        sq_time_reg  <= abs_time_reg * abs_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_en;
            v2_reg  <= v1_reg;
            hit_reg <= v2_reg && (CMP_W'(sum) < CMP_W'(dist_cut));
        end
    end

    assign stat.hit  = hit_reg;
    assign stat.busy = v1_reg || v2_reg;

endmodule

>>> rtl/size_banded_proximity_merge.sv
// Throughput: one request per cycle while idle; a vertex load does not stall the input.
// Decide: a decide stalls the input until its result is issued. When both stores hold
// vertices and the size bands pass, the pairs are walked (one pair read per cycle, stopping
// at an early close pair) and drained first; the result also waits while an earlier result
// is still held by out_stall.
// Reset: rst_n is asynchronous, active low; it clears counts, drop flag, control and output
// valid; the point memories are not cleared and are only read below their fill counts.
module size_banded_proximity_merge
    import sbpm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [COORD_BITS-1:0] coord_wire,
    input  logic signed [COORD_BITS-1:0] coord_time,
    input  logic [HITS_W-1:0]            hits_first,
    input  logic [HITS_W-1:0]            hits_second,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         merge,
    output logic [REASON_W-1:0]          reason,
    output logic                         overflow
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  first_count_reg,  first_count_next;
    logic [CNT_W-1:0]  second_count_reg, second_count_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  walk_first_reg,  walk_first_next;
    logic [CNT_W-1:0]  walk_second_reg, walk_second_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              found_reg, found_next;
    logic              rd_valid_reg;
    logic [REASON_W-1:0] pend_reason_reg, pend_reason_next;
    logic              pend_ovf_reg, pend_ovf_next;
    logic              out_valid_reg, out_valid_next;
    logic              merge_reg, merge_next;
    logic [REASON_W-1:0] reason_reg, reason_next;
    logic              overflow_reg, overflow_next;

    cfg_t              cfg;
    pair_stat_t        pair_stat;
    logic              in_accept;
    logic              wr_first, wr_second;
    logic              issue;
    logic              found_now;
    logic              last_i, last_j;
    logic              s1, s2, b1, b2;
    logic [REASON_W-1:0] size_reason;
    logic [REASON_W-1:0] final_reason;
    logic [COORD_BITS-1:0] a_wire, a_time, b_wire, b_time;

    sbpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Point memories: written on vertex loads, read one pair per cycle during the walk
    sbpm_point_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_first_store (
        .clk     (clk),
        .wr_en   (wr_first),
        .wr_addr (first_count_reg[IDX_W-1:0]),
        .wr_wire (coord_wire),
        .wr_time (coord_time),
        .rd_en   (issue),
        .rd_addr (i_reg),
        .rd_wire (a_wire),
        .rd_time (a_time)
    );

    sbpm_point_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_second_store (
        .clk     (clk),
        .wr_en   (wr_second),
        .wr_addr (second_count_reg[IDX_W-1:0]),
        .wr_wire (coord_wire),
        .wr_time (coord_time),
        .rd_en   (issue),
        .rd_addr (j_reg),
        .rd_wire (b_wire),
        .rd_time (b_time)
    );

    sbpm_pair_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_en    (rd_valid_reg),
        .a_wire   (a_wire),
        .a_time   (a_time),
        .b_wire   (b_wire),
        .b_time   (b_time),
        .dist_cut (cfg.dist_cut),
        .stat     (pair_stat)
    );

    // Take requests only while idle; loads and the decide itself are handled in the idle state
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign wr_first  = in_accept && (command == CMD_FIRST)  && (first_count_reg < CNT_MAX);
    assign wr_second = in_accept && (command == CMD_SECOND) && (second_count_reg < CNT_MAX);

    // Size bands; the first failing rule sets the reason
    assign s1 = in_band(hits_first,  cfg.small_min, cfg.small_max);
    assign s2 = in_band(hits_second, cfg.small_min, cfg.small_max);
    assign b1 = in_band(hits_first,  cfg.big_min,   cfg.big_max);
    assign b2 = in_band(hits_second, cfg.big_min,   cfg.big_max);

    always_comb
    begin
        if (!s1 && !s2)
            size_reason = REASON_NONE_SMALL;
        else if (!b1 && !b2)
            size_reason = REASON_NONE_BIG;
        else if (s1 && s2)
            size_reason = REASON_BOTH_SMALL;
        else if (b1 && b2)
            size_reason = REASON_BOTH_BIG;
        else
            size_reason = REASON_NO_CLOSE;
    end

    // Pair walk: j runs fastest over the second store, i over the first
    assign found_now = found_reg || pair_stat.hit;
    assign issue     = state_reg[1] && !found_now;
    assign last_i    = (CNT_W'(i_reg) + CNT_W'(1)) == walk_first_reg;
    assign last_j    = (CNT_W'(j_reg) + CNT_W'(1)) == walk_second_reg;

    assign final_reason = found_now ? REASON_CLOSE : pend_reason_reg;

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        walk_first_next   = walk_first_reg;
        walk_second_next  = walk_second_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        found_next        = found_now;
        pend_reason_next  = pend_reason_reg;
        pend_ovf_next     = pend_ovf_reg;
        out_valid_next    = out_valid_reg;
        merge_next        = merge_reg;
        reason_next       = reason_reg;
        overflow_next     = overflow_reg;

        // Drop the shown result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (command)
                        CMD_FIRST:
                        begin
                            if (wr_first)
                                first_count_next = first_count_reg + CNT_W'(1);
                            else
                                dropped_next = 1'b1;
                        end
                        CMD_SECOND:
                        begin
                            if (wr_second)
                                second_count_next = second_count_reg + CNT_W'(1);
                            else
                                dropped_next = 1'b1;
                        end
                        CMD_DECIDE:
                        begin
                            // Latch counts and flag, then clear for the next pair of clusters
                            pend_reason_next  = size_reason;
                            pend_ovf_next     = dropped_reg;
                            walk_first_next   = first_count_reg;
                            walk_second_next  = second_count_reg;
                            i_next            = '0;
                            j_next            = '0;
                            found_next        = 1'b0;
                            first_count_next  = '0;
                            second_count_next = '0;
                            dropped_next      = 1'b0;
                            if ((size_reason == REASON_NO_CLOSE) &&
                                (first_count_reg != '0) && (second_count_reg != '0))
                                state_next = ST_WALK;
                            else
                                state_next = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (found_now)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                        if (last_i)
                            state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                // Hold until the last issued pair has left the pipeline
                if (!rd_valid_reg && !pair_stat.busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    merge_next     = (final_reason == REASON_CLOSE);
                    reason_next    = final_reason;
                    overflow_next  = pend_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            found_reg        <= 1'b0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
            found_reg        <= found_next;
            rd_valid_reg     <= issue;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Walk bookkeeping and result payload
    always_ff @(posedge clk)
    begin
        walk_first_reg  <= walk_first_next;
        walk_second_reg <= walk_second_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        pend_reason_reg <= pend_reason_next;
        pend_ovf_reg    <= pend_ovf_next;
        merge_reg       <= merge_next;
        reason_reg      <= reason_next;
        overflow_reg    <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign merge     = merge_reg;
    assign reason    = reason_reg;
    assign overflow  = overflow_reg;

endmodule

>>> rtl/sbpm_checker.sv
// Port-level checks of the merge block, bound to the top level.
// Depends on sbpm_pkg and size_banded_proximity_merge.
module sbpm_checker
    import sbpm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [CMD_W-1:0]    command,
    input logic                out_valid,
    input logic                out_stall,
    input logic                merge,
    input logic [REASON_W-1:0] reason,
    input logic                overflow
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(merge) && $stable(reason)
                                   && $stable(overflow))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (merge == (reason == REASON_CLOSE)))
        else $error("merge disagrees with reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reason <= REASON_CLOSE))
        else $error("reason out of range");

    // A decide request blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_DECIDE) |=> in_stall)
        else $error("input open right after decide");

    // A load request never makes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command != CMD_DECIDE) && !out_valid |=> !out_valid)
        else $error("result after a load");

endmodule

bind size_banded_proximity_merge sbpm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .merge     (merge),
    .reason    (reason),
    .overflow  (overflow)
);
